// File: rtl/tft_pkg.sv
// Package with shared types and constants of the TCP flow tracker.
`timescale 1ns / 1ps
package tft_pkg;
    localparam int TableDepth  = 64;
    localparam int IdxW        = $clog2(TableDepth);
    localparam int CntW        = $clog2(TableDepth + 1);
    localparam int BufferBytes = 1048576;
    localparam int FillW       = $clog2(BufferBytes + 1);
    localparam logic [15:0] EtherIpv4 = 16'h0800;
    localparam logic [7:0]  ProtoTcp  = 8'd6;
    localparam logic [1:0]  CfgMode   = 2'd0;
    localparam logic [1:0]  CfgPort   = 2'd1;
    localparam logic [1:0]  CfgAddr   = 2'd2;
    localparam int QueueDepth = 2;

    // One classified packet as it leaves the front part.
    typedef struct packed {
        logic        accepted;
        logic [31:0] addr_high;
        logic [31:0] addr_low;
        logic [15:0] port_high;
        logic [15:0] port_low;
        logic [15:0] src_port;
        logic [15:0] payload;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SEARCH, ST_READ, ST_UPDATE, ST_OUT
    } t_state;
endpackage

// File: rtl/tft_front.sv
// Front part: filters, classifies and queues incoming packets.
`timescale 1ns / 1ps
module tft_front import tft_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_ether_type,
    input  logic [7:0]  i_ip_protocol,
    input  logic [31:0] i_src_address,
    input  logic [31:0] i_dst_address,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_dst_port,
    input  logic [15:0] i_ip_total_length,
    input  logic [3:0]  i_tcp_header_words,
    input  logic [1:0]  i_filter_mode,
    input  logic [15:0] i_filter_port,
    input  logic [31:0] i_filter_address,
    output logic        o_q_valid,
    output t_item       o_q_item,
    input  logic        i_q_pop
);
    t_item r_q [QueueDepth];
    logic  r_wp, r_rp;
    logic [1:0] r_cnt;
    t_item item;
    logic  push, addr_ok, port_ok;
    logic [16:0] hdr;

    always_comb begin
        addr_ok = (i_src_address == i_filter_address) || (i_dst_address == i_filter_address);
        port_ok = (i_src_port == i_filter_port) || (i_dst_port == i_filter_port);
        hdr = 17'd20 + {11'd0, i_tcp_header_words, 2'b00};
        item.accepted = (i_ether_type == EtherIpv4) && (i_ip_protocol == ProtoTcp)
                      && !(i_filter_mode[0] && !addr_ok) && !(i_filter_mode[1] && !port_ok);
        item.addr_high = (i_src_address > i_dst_address) ? i_src_address : i_dst_address;
        item.addr_low  = (i_src_address > i_dst_address) ? i_dst_address : i_src_address;
        item.port_high = (i_src_port > i_dst_port) ? i_src_port : i_dst_port;
        item.port_low  = (i_src_port > i_dst_port) ? i_dst_port : i_src_port;
        item.src_port  = i_src_port;
        item.payload   = ({1'b0, i_ip_total_length} > hdr)
                       ? 16'(({1'b0, i_ip_total_length} - hdr)) : 16'd0;
    end

    assign o_stall   = (r_cnt == 2'(QueueDepth));
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_q_pop |-> o_q_valid)
        else $error("pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'(QueueDepth))
        else $error("queue count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !i_q_pop) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("queue count missed a push");
endmodule

// File: rtl/tft_back.sv
// Back part: searches the connection table and updates the counters.
`timescale 1ns / 1ps
module tft_back import tft_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  t_item           i_q_item,
    output logic            o_q_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic            o_accepted,
    output logic            o_new_connection,
    output logic [5:0]      o_connection_index,
    output logic            o_upstream,
    output logic [15:0]     o_payload_bytes,
    output logic [20:0]     o_payload_offset,
    output logic [31:0]     o_direction_bytes,
    output logic            o_table_full,
    output logic            o_buffer_overflow,
    output logic [31:0]     o_packet_count,
    output logic [6:0]      o_connection_count,
    output logic [47:0]     o_total_payload
);
    // Key and count memories; entries beyond the fill count are never compared.
    logic [95:0] r_key_mem [TableDepth];
    logic [15:0] r_fsp_mem [TableDepth];
    logic [31:0] r_up_mem  [TableDepth];
    logic [31:0] r_dn_mem  [TableDepth];

    t_state r_state, n_state;
    t_item  r_item;
    logic [CntW-1:0] r_used, r_scan;
    logic [IdxW-1:0] r_idx;
    logic [95:0] r_key_rd;
    logic [15:0] r_fsp_rd;
    logic [31:0] r_up_rd, r_dn_rd;
    logic        r_new, r_full;
    logic [31:0] r_pkts;
    logic [47:0] r_total;
    logic [FillW-1:0] r_fill;
    logic        hit, scan_done, up;
    logic [31:0] dir;
    logic [FillW:0] sum_fill;

    assign hit = (r_key_rd == {r_item.addr_high, r_item.addr_low,
                               r_item.port_high, r_item.port_low});

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_q_valid) n_state = i_q_item.accepted ? ST_SEARCH : ST_OUT;
            ST_SEARCH: if (r_scan == r_used || (r_scan != '0 && hit)) n_state = ST_READ;
            ST_READ:   n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_OUT;
            ST_OUT:    if (!i_stall) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // The search reads entry r_scan while comparing the entry read the cycle before.
    assign scan_done = (r_state == ST_SEARCH) && (r_scan == r_used || (r_scan != '0 && hit));
    assign up  = r_new ? 1'b1 : (r_fsp_rd == r_item.src_port);
    assign dir = r_new ? {16'd0, r_item.payload}
                       : ((up ? r_up_rd : r_dn_rd) + {16'd0, r_item.payload});
    assign sum_fill = {1'b0, r_fill} + (FillW+1)'(r_item.payload);
    assign o_q_pop = (r_state == ST_IDLE) && i_q_valid;
    assign o_valid = (r_state == ST_OUT);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SEARCH && r_scan < CntW'(TableDepth)) begin
            r_key_rd <= r_key_mem[r_scan[IdxW-1:0]];
        end
        if (r_state == ST_READ) begin
            r_fsp_rd <= r_fsp_mem[r_idx];
            r_up_rd  <= r_up_mem[r_idx];
            r_dn_rd  <= r_dn_mem[r_idx];
        end
        if (r_state == ST_SEARCH && scan_done && !(r_scan != '0 && hit)
            && r_used != CntW'(TableDepth)) begin
            r_key_mem[r_used[IdxW-1:0]] <= {r_item.addr_high, r_item.addr_low,
                                            r_item.port_high, r_item.port_low};
            r_fsp_mem[r_used[IdxW-1:0]] <= r_item.src_port;
        end
        // A new entry starts both byte counts, so the reverse direction begins at zero.
        if (r_state == ST_UPDATE && !r_full) begin
            if (r_new) begin
                r_up_mem[r_idx] <= dir;
                r_dn_mem[r_idx] <= 32'd0;
            end else if (up) begin
                r_up_mem[r_idx] <= dir;
            end else begin
                r_dn_mem[r_idx] <= dir;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_item;
        end
        if (r_state == ST_UPDATE) begin
            o_upstream         <= !r_full && up;
            o_direction_bytes  <= r_full ? 32'd0 : dir;
            o_payload_offset   <= 21'(r_fill);
            o_buffer_overflow  <= sum_fill > (FillW+1)'(BufferBytes);
            o_payload_bytes    <= r_item.payload;
            o_connection_index <= r_full ? 6'd0 : 6'(r_idx);
        end else if (o_q_pop) begin
            o_upstream <= 1'b0; o_direction_bytes <= '0; o_payload_offset <= '0;
            o_buffer_overflow <= 1'b0; o_payload_bytes <= '0; o_connection_index <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_used <= '0; r_pkts <= '0; r_total <= '0; r_fill <= '0;
            r_scan <= '0; r_idx <= '0; r_new <= 1'b0; r_full <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_q_pop) begin
                r_scan <= '0; r_new <= 1'b0; r_full <= 1'b0;
            end
            if (r_state == ST_SEARCH) begin
                r_scan <= r_scan + CntW'(1);
                if (r_scan != '0 && hit) begin
                    r_idx <= IdxW'(r_scan - CntW'(1));
                end else if (scan_done) begin
                    if (r_used == CntW'(TableDepth)) begin
                        r_full <= 1'b1;
                    end else begin
                        r_idx <= r_used[IdxW-1:0];
                        r_new <= 1'b1;
                        r_used <= r_used + CntW'(1);
                    end
                end
            end
            if (r_state == ST_UPDATE) begin
                r_pkts <= r_pkts + 32'd1;
                r_total <= r_total + {32'd0, r_item.payload};
                r_fill <= (sum_fill > (FillW+1)'(BufferBytes)) ? FillW'(BufferBytes)
                                                               : sum_fill[FillW-1:0];
            end
        end
    end

    assign o_accepted         = r_item.accepted;
    assign o_new_connection   = r_new;
    assign o_table_full       = r_full;
    assign o_packet_count     = r_pkts;
    assign o_connection_count = 7'(r_used);
    assign o_total_payload    = r_total;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_used <= CntW'(TableDepth))
        else $error("fill count beyond table depth");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) !(r_new && r_full))
        else $error("new entry and table full together");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_q_item.accepted) |=> !o_valid)
        else $error("result before processing");
endmodule

// File: rtl/tcp_flow_tracker_unit.sv
// Top level of the TCP flow tracker: configuration registers and the two parts.
// Flow: a rejected packet goes from the queue straight to the result; an accepted packet is
// searched, read and updated first, the search walking up to 64 stored connections.
// Throughput: one packet at a time in the back part, set by the one-entry-a-cycle search
// through the key memory; a two-entry queue lets the input side run ahead.
// Reset: synchronous, active low; clears the table fill count, counters and filter setup.
`timescale 1ns / 1ps
module tcp_flow_tracker_unit import tft_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_ether_type,
    input  logic [7:0]  i_ip_protocol,
    input  logic [31:0] i_src_address,
    input  logic [31:0] i_dst_address,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_dst_port,
    input  logic [15:0] i_ip_total_length,
    input  logic [3:0]  i_tcp_header_words,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_accepted,
    output logic        o_new_connection,
    output logic [5:0]  o_connection_index,
    output logic        o_upstream,
    output logic [15:0] o_payload_bytes,
    output logic [20:0] o_payload_offset,
    output logic [31:0] o_direction_bytes,
    output logic        o_table_full,
    output logic        o_buffer_overflow,
    output logic [31:0] o_packet_count,
    output logic [6:0]  o_connection_count,
    output logic [47:0] o_total_payload
);
    logic [1:0]  r_filter_mode;
    logic [15:0] r_filter_port;
    logic [31:0] r_filter_address;
    logic        q_valid, q_pop;
    t_item       q_item;

    // Configuration transfers are always taken; unknown indexes are ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_mode <= '0;
            r_filter_port <= '0;
            r_filter_address <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CfgMode: r_filter_mode <= i_cfg_data[1:0];
                CfgPort: r_filter_port <= i_cfg_data[15:0];
                CfgAddr: r_filter_address <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tft_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_ether_type, .i_ip_protocol, .i_src_address, .i_dst_address,
        .i_src_port, .i_dst_port, .i_ip_total_length, .i_tcp_header_words,
        .i_filter_mode(r_filter_mode), .i_filter_port(r_filter_port),
        .i_filter_address(r_filter_address),
        .o_q_valid(q_valid), .o_q_item(q_item), .i_q_pop(q_pop)
    );

    tft_back u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .i_q_item(q_item), .o_q_pop(q_pop),
        .o_valid, .i_stall, .o_accepted, .o_new_connection, .o_connection_index,
        .o_upstream, .o_payload_bytes, .o_payload_offset, .o_direction_bytes,
        .o_table_full, .o_buffer_overflow, .o_packet_count, .o_connection_count,
        .o_total_payload
    );
endmodule
